/* design/lctt_pkg.sv */
// ----------------------------------------------------------------------------
// lctt_pkg: shared types and constants of the trace taper
// Register indexes, status codes, weight format and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lctt_pkg;

    // configuration register file
    localparam int REG_W     = 21;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_ZERO_END   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FULL_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FULL_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_ZERO_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_LENGTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_ENABLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COSINE_SHAPE    = 3'd6;

    // taper status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HEAD_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TAIL_BAD  = 2'd2;

    // weights are unsigned Q1.16
    localparam int FRAC_W = 16;
    localparam int Q_W    = FRAC_W + 1;
    localparam logic [Q_W-1:0] W_ONE  = 17'h10000;
    localparam logic [Q_W-1:0] W_ZERO = 17'h00000;
    localparam int ROUND_HALF = 32768;

    // ramp dividend: below divisor * 2^Q_W, divisor below 2^REG_W
    localparam int DVD_W = REG_W + Q_W;

    // cosine table generation, Q30
    localparam longint COS_ONE_Q30 = 64'd1073741824;
    localparam longint COS_PI_Q30  = 64'd3373259426;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic classify;
        logic start_head;
        logic start_tail;
        logic latch_head;
        logic latch_tail;
        logic combine;
        logic mult;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic h_div;
        logic t_div;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

/* design/lctt_div.sv */
// ----------------------------------------------------------------------------
// lctt_div: restoring divider for the ramp weights
// One quotient bit per cycle, Q_W bits. The dividend is always below
// divisor * 2^Q_W, so the upper part seeds the remainder directly.
// ----------------------------------------------------------------------------
module lctt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lctt_pkg::DVD_W-1:0]  i_dividend,
    input  logic [lctt_pkg::REG_W-1:0]  i_divisor,
    output logic [lctt_pkg::Q_W-1:0]    o_quot,
    output logic                        o_busy,
    output logic                        o_done
);
    import lctt_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [REG_W-1:0] r_rem;
    logic [REG_W-1:0] r_den;
    logic [Q_W-1:0]   r_low;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REG_W:0]   trial;
    logic             ge;
    logic [REG_W-1:0] n_rem;
    logic [Q_W-1:0]   n_low;

    // one trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_low[Q_W-1]};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? REG_W'(trial - {1'b0, r_den}) : trial[REG_W-1:0];
        n_low = {r_low[Q_W-2:0], ge};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVD_W-1:Q_W];
            r_low <= i_dividend[Q_W-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
    end

    assign o_quot = r_low;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

/* design/lctt_datapath.sv */
// ----------------------------------------------------------------------------
// lctt_datapath: registers, weights and products of the trace taper
// Holds the configuration, the sample index, the zone classification, the
// shared ramp divider, the cosine table, the weight multiplier, the
// per-component multipliers and the output register.
// ----------------------------------------------------------------------------
module lctt_datapath #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int MAX_TRACE_LEN   = 1048576,
    parameter int COS_TABLE_DEPTH = 256,
    parameter int COMPONENTS      = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lctt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lctt_pkg::REG_W-1:0]        i_cfg_wdata,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample_x,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample_y,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample_z,
    input  logic                              i_last_sample,
    input  lctt_pkg::t_cmd                    i_cmd,
    output lctt_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]    o_tapered_x,
    output logic signed [SAMPLE_WIDTH-1:0]    o_tapered_y,
    output logic signed [SAMPLE_WIDTH-1:0]    o_tapered_z,
    output logic                              o_last_out,
    output logic [lctt_pkg::STATUS_W-1:0]     o_taper_status
);
    import lctt_pkg::*;

    localparam int IDX_W   = $clog2(MAX_TRACE_LEN);
    localparam int CW      = ((IDX_W > REG_W) ? IDX_W : REG_W) + 2;
    localparam int ROM_AW  = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PROD_W  = SAMPLE_WIDTH + Q_W + 1;
    localparam int NLANE   = 3;
    localparam logic signed [CW-1:0] S_ONE = 1;

    typedef logic [Q_W-1:0] t_cos_rom [0:COS_TABLE_DEPTH];

    // cos(pi*k/depth) in Q30 by Taylor series, clamped to [0, 1]
    function automatic longint cos_q30(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (COS_PI_Q30 * 64'(k)) / 64'(COS_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = COS_ONE_Q30;
        sum  = COS_ONE_Q30;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > COS_ONE_Q30) begin
            sum = COS_ONE_Q30;
        end
        return sum;
    endfunction

    // raised half-cosine table, Q16, built at elaboration
    function automatic t_cos_rom build_cos_rom();
        t_cos_rom rom;
        longint   r;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            if (2 * k <= COS_TABLE_DEPTH) begin
                r = (COS_ONE_Q30 - cos_q30(k)) / 2;
            end else begin
                r = (COS_ONE_Q30 + cos_q30(COS_TABLE_DEPTH - k)) / 2;
            end
            rom[k] = Q_W'((r + 8192) >>> 14);
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_rom();

    // ramp numerator scaled for the divider
    function automatic logic [DVD_W-1:0] scale_num(input logic [REG_W-1:0] v,
                                                   input logic cos_sel);
        if (cos_sel) begin
            return DVD_W'(v) * DVD_W'(COS_TABLE_DEPTH);
        end
        return DVD_W'({v, {FRAC_W{1'b0}}});
    endfunction

    // configuration registers
    logic signed [REG_W-1:0] r_hze;
    logic signed [REG_W-1:0] r_hfs;
    logic signed [REG_W-1:0] r_tfe;
    logic signed [REG_W-1:0] r_tzs;
    logic [REG_W-1:0]        r_tl;
    logic [1:0]              r_en;
    logic                    r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hze <= '0;
            r_hfs <= '0;
            r_tfe <= 21'h0FFFFF;
            r_tzs <= 21'h0FFFFF;
            r_tl  <= 21'h100000;
            r_en  <= 2'b00;
            r_cos <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_HEAD_ZERO_END:   r_hze <= i_cfg_wdata;
                CFG_HEAD_FULL_START: r_hfs <= i_cfg_wdata;
                CFG_TAIL_FULL_END:   r_tfe <= i_cfg_wdata;
                CFG_TAIL_ZERO_START: r_tzs <= i_cfg_wdata;
                CFG_TRACE_LENGTH:    r_tl  <= i_cfg_wdata;
                CFG_SIDE_ENABLE:     r_en  <= i_cfg_wdata[1:0];
                CFG_COSINE_SHAPE:    r_cos <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input capture
    logic signed [SAMPLE_WIDTH-1:0] r_smp [NLANE];
    logic                           r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_smp[0] <= i_sample_x;
            r_smp[1] <= i_sample_y;
            r_smp[2] <= i_sample_z;
            r_last   <= i_last_sample;
        end
    end

    // sample index, advanced once the current item is classified
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W:0]   idx_inc;

    assign idx_inc = {1'b0, r_idx} + (IDX_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.classify) begin
            if (r_last || (idx_inc >= (IDX_W + 1)'(MAX_TRACE_LEN))) begin
                r_idx <= '0;
            end else begin
                r_idx <= idx_inc[IDX_W-1:0];
            end
        end
    end

    // zone classification
    logic signed [CW-1:0] s_idx, s_hze, s_hfs, s_tfe, s_tzs, s_tlm1;
    logic signed [CW-1:0] h_num_f, h_den_f, t_num_f, t_den_f;
    logic [REG_W-1:0]     h_num, h_den, t_num, t_den;
    logic                 head_on, tail_on, head_bad, tail_bad;
    logic [STATUS_W-1:0]  n_status;
    logic [Q_W-1:0]       n_wh, n_wt;
    logic                 n_h_div, n_t_div;
    logic [DVD_W-1:0]     n_h_dvd, n_t_dvd;

    always_comb begin
        s_idx  = $signed({{(CW - IDX_W){1'b0}}, r_idx});
        s_hze  = CW'(r_hze);
        s_hfs  = CW'(r_hfs);
        s_tfe  = CW'(r_tfe);
        s_tzs  = CW'(r_tzs);
        s_tlm1 = $signed({{(CW - REG_W){1'b0}}, r_tl}) - S_ONE;

        h_num_f = s_idx - s_hze;
        h_den_f = s_hfs - s_hze;
        t_num_f = s_idx - s_tfe;
        t_den_f = s_tzs - s_tfe;
        h_num   = h_num_f[REG_W-1:0];
        h_den   = h_den_f[REG_W-1:0];
        t_num   = t_num_f[REG_W-1:0];
        t_den   = t_den_f[REG_W-1:0];

        head_on  = r_en[0] && (s_hfs > s_hze);
        tail_on  = r_en[1] && (s_tzs > s_tfe);
        head_bad = head_on && (s_tlm1 < s_hze);
        tail_bad = tail_on && r_tzs[REG_W-1];

        n_status = STATUS_OK;
        n_wh     = W_ONE;
        n_wt     = W_ONE;
        n_h_div  = 1'b0;
        n_t_div  = 1'b0;
        if (head_bad) begin
            n_status = STATUS_HEAD_BAD;
        end else begin
            if (head_on) begin
                if (s_idx < s_hze) begin
                    n_wh = W_ZERO;
                end else if (s_idx < s_hfs) begin
                    n_h_div = 1'b1;
                end
            end
            if (tail_bad) begin
                n_status = STATUS_TAIL_BAD;
            end else if (tail_on) begin
                if (s_idx >= s_tzs) begin
                    n_wt = W_ZERO;
                end else if (s_idx >= s_tfe) begin
                    n_t_div = 1'b1;
                end
            end
        end

        // the linear tail divides the remaining distance so it falls
        n_h_dvd = scale_num(h_num, r_cos) + DVD_W'(h_den >> 1);
        n_t_dvd = scale_num(r_cos ? t_num : (t_den - t_num), r_cos)
                + DVD_W'(t_den >> 1);
    end

    logic [STATUS_W-1:0] r_status;
    logic [Q_W-1:0]      r_wh, r_wt, r_w;
    logic                r_h_div, r_t_div;
    logic [DVD_W-1:0]    r_h_dvd, r_t_dvd;
    logic [REG_W-1:0]    r_h_den, r_t_den;
    logic [Q_W-1:0]      r_rom_q;
    logic [Q_W-1:0]      quot;
    logic                div_busy, div_done;
    logic [ROM_AW-1:0]   rom_addr;

    // shared ramp divider
    lctt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_head || i_cmd.start_tail),
        .i_dividend (i_cmd.start_tail ? r_t_dvd : r_h_dvd),
        .i_divisor  (i_cmd.start_tail ? r_t_den : r_h_den),
        .o_quot     (quot),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    // cosine table read, registered
    assign rom_addr = (quot > Q_W'(COS_TABLE_DEPTH)) ? ROM_AW'(COS_TABLE_DEPTH)
                                                     : quot[ROM_AW-1:0];

    always_ff @(posedge i_clk) begin
        r_rom_q <= COS_ROM[rom_addr];
    end

    // weights
    logic [2*Q_W-1:0] wprod;

    assign wprod = (2 * Q_W)'(r_wh) * (2 * Q_W)'(r_wt) + (2 * Q_W)'(ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (i_cmd.classify) begin
            r_status <= n_status;
            r_wh     <= n_wh;
            r_wt     <= n_wt;
            r_h_dvd  <= n_h_dvd;
            r_t_dvd  <= n_t_dvd;
            r_h_den  <= h_den;
            r_t_den  <= t_den;
        end
        if (i_cmd.latch_head) begin
            r_wh <= r_cos ? r_rom_q : quot;
        end
        if (i_cmd.latch_tail) begin
            r_wt <= r_cos ? (W_ONE - r_rom_q) : quot;
        end
        if (i_cmd.combine) begin
            r_w <= wprod[FRAC_W+Q_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_div <= 1'b0;
            r_t_div <= 1'b0;
        end else if (i_cmd.classify) begin
            r_h_div <= n_h_div;
            r_t_div <= n_t_div;
        end
    end

    // per-component products with round half up
    logic signed [PROD_W-1:0]       lane_p [NLANE];
    logic signed [SAMPLE_WIDTH-1:0] r_res  [NLANE];

    always_comb begin
        for (int c = 0; c < NLANE; c++) begin
            lane_p[c] = r_smp[c] * $signed({1'b0, r_w}) + PROD_W'(ROUND_HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            for (int c = 0; c < NLANE; c++) begin
                if (c < COMPONENTS) begin
                    r_res[c] <= lane_p[c][SAMPLE_WIDTH+FRAC_W-1:FRAC_W];
                end else begin
                    r_res[c] <= '0;
                end
            end
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_tapered_x    <= r_res[0];
            o_tapered_y    <= r_res[1];
            o_tapered_z    <= r_res[2];
            o_last_out     <= r_last;
            o_taper_status <= r_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.h_div    = r_h_div;
    assign o_sts.t_div    = r_t_div;
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

/* design/lctt_ctrl.sv */
// ----------------------------------------------------------------------------
// lctt_ctrl: sequencer of the trace taper
// Steps one sample through classification, up to two ramp divisions,
// weight combination, the component products and the output register.
// ----------------------------------------------------------------------------
module lctt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lctt_pkg::t_sts  i_sts,
    output lctt_pkg::t_cmd  o_cmd
);
    import lctt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_SEL   = 4'd2;
    localparam logic [3:0] S_HDIV  = 4'd3;
    localparam logic [3:0] S_HLAT  = 4'd4;
    localparam logic [3:0] S_TDIV  = 4'd5;
    localparam logic [3:0] S_TLAT  = 4'd6;
    localparam logic [3:0] S_COMB  = 4'd7;
    localparam logic [3:0] S_MULT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state        = S_SEL;
            end
            S_SEL: begin
                if (i_sts.h_div) begin
                    o_cmd.start_head = 1'b1;
                    n_state          = S_HDIV;
                end else if (i_sts.t_div) begin
                    o_cmd.start_tail = 1'b1;
                    n_state          = S_TDIV;
                end else begin
                    n_state = S_COMB;
                end
            end
            S_HDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_HLAT;
                end
            end
            S_HLAT: begin
                o_cmd.latch_head = 1'b1;
                if (i_sts.t_div) begin
                    o_cmd.start_tail = 1'b1;
                    n_state          = S_TDIV;
                end else begin
                    n_state = S_COMB;
                end
            end
            S_TDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_TLAT;
                end
            end
            S_TLAT: begin
                o_cmd.latch_tail = 1'b1;
                n_state          = S_COMB;
            end
            S_COMB: begin
                o_cmd.combine = 1'b1;
                n_state       = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* design/linear_cosine_trace_taper.sv */
// ----------------------------------------------------------------------------
// linear_cosine_trace_taper: head and tail taper of a three-component trace
// Linear or raised half-cosine ramps, index counted per trace.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis stream, one three-component sample per
//   transaction, tlast on the final sample of a trace (it restarts the index).
//   Tapered samples leave on the m_axis stream with tlast copied and the
//   taper status in tuser. The user writes registers on the cfg port only
//   while the block is idle (not enforced); they take effect on the next sample.
//   One sample is processed at a time. Outside both ramps a sample passes
//   through load, classify, select, combine, multiply and the output load;
//   each ramp adds a pass through the bit-serial divider (17 quotient bits),
//   its done flag and the weight latch.
//   The next sample is accepted while the previous result still waits in the
//   output register; a stalled receiver holds only the final load step.
//   Reset (synchronous, active low) restores the register defaults, clears
//   the sample index and drops any result in flight. The cosine table is a
//   constant and needs no initialization pass.
// ----------------------------------------------------------------------------
module linear_cosine_trace_taper #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int MAX_TRACE_LEN   = 1048576,
    parameter int COS_TABLE_DEPTH = 256,
    parameter int COMPONENTS      = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [lctt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lctt_pkg::REG_W-1:0]            i_cfg_wdata,
    // input samples
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // sample_x, sample_y, sample_z, zero fill
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    input  logic                                  i_s_axis_tlast,
    // tapered samples
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tapered_x, tapered_y, tapered_z, zero fill
    output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]   o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // taper_status
    output logic [lctt_pkg::STATUS_W-1:0]         o_m_axis_tuser
);
    import lctt_pkg::*;

    localparam int DATA_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;

    t_cmd cmd;
    t_sts sts;

    logic signed [SAMPLE_WIDTH-1:0] tap_x, tap_y, tap_z;

    // sequencer
    lctt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    lctt_datapath #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .MAX_TRACE_LEN   (MAX_TRACE_LEN),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .COMPONENTS      (COMPONENTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_x     (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_sample_y     (i_s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_sample_z     (i_s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]),
        .i_last_sample  (i_s_axis_tlast),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_tapered_x    (tap_x),
        .o_tapered_y    (tap_y),
        .o_tapered_z    (tap_z),
        .o_last_out     (o_m_axis_tlast),
        .o_taper_status (o_m_axis_tuser)
    );

    // pack output components, zero fill on top
    assign o_m_axis_tdata = DATA_W'({tap_z, tap_y, tap_x});

    // checks
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a sample is in progress");

    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("output register overwritten before it was taken");

    a_div_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.div_done |=> (cmd.latch_head || cmd.latch_tail))
        else $error("ramp quotient not latched after division");

    a_single_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.start_head || cmd.start_tail) |-> (!sts.div_busy &&
        !(cmd.start_head && cmd.start_tail)))
        else $error("divider started while busy or for both sides");

endmodule
